FILE: src/bsm_pkg.sv
// Shared codes for the bounding sphere merge block.
`timescale 1ns / 1ps
package bsm_pkg;

  localparam logic [1:0] CASE_KEEP_A = 2'd0;
  localparam logic [1:0] CASE_TAKE_B = 2'd1;
  localparam logic [1:0] CASE_NEW    = 2'd2;

endpackage

FILE: src/bsm_front.sv
// Front stages: center and radius differences, squared length and containment test.
`timescale 1ns / 1ps
module bsm_front #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic signed [W-1:0] a_c [3],
  input  logic signed [W-1:0] b_c [3],
  input  logic [W-2:0]        ra,
  input  logic [W-2:0]        rb,
  output logic                out_valid,
  output logic [2*W+3:0]      l2,
  output logic signed [W-1:0] a_o [3],
  output logic signed [W-1:0] b_o [3],
  output logic [W-2:0]        ra_o,
  output logic [W-2:0]        rb_o,
  output logic [W:0]          dmag_o [3],
  output logic [2:0]          dneg_o,
  output logic signed [W-1:0] rd_o,
  output logic                contain_o,
  output logic                take_a_o
);

  logic                v_r [3];
  logic signed [W-1:0] a_r [3][3];
  logic signed [W-1:0] b_r [3][3];
  logic [W-2:0]        ra_r [3];
  logic [W-2:0]        rb_r [3];
  logic [W:0]          dmag_r [3][3];
  logic [2:0]          dneg_r [3];
  logic signed [W-1:0] rd_r [3];
  logic [W-2:0]        rdmag_r;
  logic [2*W+1:0]      sq_r [3];
  logic [2*W-3:0]      rdsq_r;
  logic [2*W+3:0]      l2_r;
  logic                contain_r;
  logic                take_a_r [2];

  logic [W:0]          d_nxt [3];
  logic [W:0]          dmag_nxt [3];
  logic [2:0]          dneg_nxt;
  logic [W-1:0]        rd_nxt;
  logic [W-2:0]        rdmag_nxt;
  logic [2*W+3:0]      l2_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_nxt[k]    = {b_c[k][W-1], b_c[k]} - {a_c[k][W-1], a_c[k]};
      dneg_nxt[k] = d_nxt[k][W];
      dmag_nxt[k] = d_nxt[k][W] ? (~d_nxt[k] + 1'b1) : d_nxt[k];
    end
    rd_nxt    = {1'b0, rb} - {1'b0, ra};
    rdmag_nxt = rd_nxt[W-1] ? (~rd_nxt[W-2:0] + 1'b1) : rd_nxt[W-2:0];
    l2_nxt    = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 3; j++) v_r[j] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[0]    <= a_c;
      b_r[0]    <= b_c;
      ra_r[0]   <= ra;
      rb_r[0]   <= rb;
      dmag_r[0] <= dmag_nxt;
      dneg_r[0] <= dneg_nxt;
      rd_r[0]   <= rd_nxt;
      rdmag_r   <= rdmag_nxt;
      for (int j = 1; j < 3; j++) begin
        a_r[j]    <= a_r[j-1];
        b_r[j]    <= b_r[j-1];
        ra_r[j]   <= ra_r[j-1];
        rb_r[j]   <= rb_r[j-1];
        dmag_r[j] <= dmag_r[j-1];
        dneg_r[j] <= dneg_r[j-1];
        rd_r[j]   <= rd_r[j-1];
      end
      for (int k = 0; k < 3; k++) sq_r[k] <= dmag_r[0][k] * dmag_r[0][k];
      rdsq_r      <= rdmag_r * rdmag_r;
      take_a_r[0] <= rd_r[0][W-1] || (rd_r[0] == '0);
      take_a_r[1] <= take_a_r[0];
      l2_r        <= l2_nxt;
      contain_r   <= {6'd0, rdsq_r} >= l2_nxt;
    end
  end

  assign out_valid = v_r[2];
  assign l2        = l2_r;
  assign a_o       = a_r[2];
  assign b_o       = b_r[2];
  assign ra_o      = ra_r[2];
  assign rb_o      = rb_r[2];
  assign dmag_o    = dmag_r[2];
  assign dneg_o    = dneg_r[2];
  assign rd_o      = rd_r[2];
  assign contain_o = contain_r;
  assign take_a_o  = take_a_r[1];

endmodule

FILE: src/bsm_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a side channel.
`timescale 1ns / 1ps
module bsm_sqrt #(
  parameter int LB = 34,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [2*LB-1:0] n,
  input  logic [SW-1:0]   side,
  output logic            out_valid,
  output logic [LB-1:0]   root,
  output logic [SW-1:0]   side_o
);

  logic            v_r    [LB];
  logic [LB-1:0]   root_r [LB];
  logic [LB+1:0]   rem_r  [LB];
  logic [2*LB-1:0] n_r    [LB];
  logic [SW-1:0]   side_r [LB];

  for (genvar i = 0; i < LB; i++) begin : g_st
    logic            v_i;
    logic [LB-1:0]   root_i;
    logic [LB+1:0]   rem_i;
    logic [2*LB-1:0] n_i;
    logic [SW-1:0]   side_i;
    logic [LB+3:0]   trial;
    logic [LB+3:0]   t;
    logic [LB+3:0]   diff;

    if (i == 0) begin : g_first
      assign v_i    = in_valid;
      assign root_i = '0;
      assign rem_i  = '0;
      assign n_i    = n;
      assign side_i = side;
    end else begin : g_next
      assign v_i    = v_r[i-1];
      assign root_i = root_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign n_i    = n_r[i-1];
      assign side_i = side_r[i-1];
    end

    always_comb begin
      trial = {rem_i, n_i[2*(LB-1-i)+1 -: 2]};
      t     = {2'b00, root_i, 2'b01};
      diff  = trial - t;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[i]    <= n_i;
        side_r[i] <= side_i;
        if (trial >= t) begin
          rem_r[i]  <= diff[LB+1:0];
          root_r[i] <= {root_i[LB-2:0], 1'b1};
        end else begin
          rem_r[i]  <= trial[LB+1:0];
          root_r[i] <= {root_i[LB-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[LB-1];
  assign root      = root_r[LB-1];
  assign side_o    = side_r[LB-1];

endmodule

FILE: src/bsm_div.sv
// Three-lane pipelined divider for the center offsets, one quotient bit per stage.
`timescale 1ns / 1ps
module bsm_div #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [W+1:0]        len,
  input  logic signed [W-1:0] rd,
  input  logic [W:0]          dmag [3],
  input  logic [SW-1:0]       side,
  output logic                out_valid,
  output logic [W:0]          quot [3],
  output logic [W+2:0]        rem [3],
  output logic [W+2:0]        den,
  output logic [SW-1:0]       side_o
);

  localparam int QB = W + 1;
  localparam int NB = 2 * W + 4;
  localparam int RB = W + 3;

  logic          v0_r;
  logic [NB-1:0] prod_r [3];
  logic [RB-1:0] den0_r;
  logic [SW-1:0] side0_r;
  logic [RB-1:0] s_nxt;

  assign s_nxt = {1'b0, len} + {{3{rd[W-1]}}, rd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) prod_r[k] <= dmag[k] * s_nxt;
      den0_r  <= {len, 1'b0};
      side0_r <= side;
    end
  end

  logic          v_r    [QB];
  logic [QB-1:0] q_r    [QB][3];
  logic [RB-1:0] rem_r  [QB][3];
  logic [QB-1:0] low_r  [QB][3];
  logic [RB-1:0] den_r  [QB];
  logic [SW-1:0] side_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_st
    logic          v_i;
    logic [QB-1:0] q_i   [3];
    logic [RB-1:0] rem_i [3];
    logic [QB-1:0] low_i [3];
    logic [RB-1:0] den_i;
    logic [SW-1:0] side_i;
    logic [RB:0]   trial [3];
    logic [RB:0]   diff  [3];

    if (j == 0) begin : g_first
      assign v_i    = v0_r;
      assign den_i  = den0_r;
      assign side_i = side0_r;
      for (genvar k = 0; k < 3; k++) begin : g_ln
        assign q_i[k]   = '0;
        assign rem_i[k] = prod_r[k][NB-1:QB];
        assign low_i[k] = prod_r[k][QB-1:0];
      end
    end else begin : g_next
      assign v_i    = v_r[j-1];
      assign den_i  = den_r[j-1];
      assign side_i = side_r[j-1];
      assign q_i    = q_r[j-1];
      assign rem_i  = rem_r[j-1];
      assign low_i  = low_r[j-1];
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = {rem_i[k], low_i[k][QB-1-j]};
        diff[k]  = trial[k] - {1'b0, den_i};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (adv) begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[j]  <= den_i;
        side_r[j] <= side_i;
        low_r[j]  <= low_i;
        for (int k = 0; k < 3; k++) begin
          if (trial[k] >= {1'b0, den_i}) begin
            rem_r[j][k] <= diff[k][RB-1:0];
            q_r[j][k]   <= {q_i[k][QB-2:0], 1'b1};
          end else begin
            rem_r[j][k] <= trial[k][RB-1:0];
            q_r[j][k]   <= {q_i[k][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign quot      = q_r[QB-1];
  assign rem       = rem_r[QB-1];
  assign den       = den_r[QB-1];
  assign side_o    = side_r[QB-1];

endmodule

FILE: src/bounding_sphere_merge.sv
// Top level of the bounding sphere merge pipeline.
`timescale 1ns / 1ps
// Merges two spheres into the smallest sphere enclosing both, one request per cycle
// with no bubbles while the output is not held. A request passes through the front
// stages, the bit-serial square-root stages, the divider product register, the
// one-bit-per-stage offset dividers and the output register. The whole pipeline
// stalls together while a result waits at the output register.
module bounding_sphere_merge #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // a_center_x, a_center_y, a_center_z, a_radius, b_center_x, b_center_y,
  // b_center_z, b_radius
  input  logic [((8*COORD_WIDTH-2+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // merged_center_x, merged_center_y, merged_center_z, merged_radius
  output logic [((4*COORD_WIDTH-1+7)/8)*8-1:0] out_tdata,
  // merge_case, radius_saturated
  output logic [2:0] out_tuser
);
  import bsm_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int LB  = W + 2;
  localparam int KW  = 8 * W + 3;
  localparam int SQW = KW + 3 * (W + 1) + W;
  localparam int DVW = KW + LB;
  localparam int OTW = ((4 * W - 1 + 7) / 8) * 8;
  localparam logic [LB:0] RMAX = {{(LB-W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic adv;
  logic out_valid_r;
  logic signed [W-1:0] out_c_r [3];
  logic [W-2:0] out_r_r;
  logic [1:0] out_case_r;
  logic out_sat_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  logic signed [W-1:0] a_c [3];
  logic signed [W-1:0] b_c [3];
  logic [W-2:0] ra, rb;

  assign a_c[0] = in_tdata[0 +: W];
  assign a_c[1] = in_tdata[W +: W];
  assign a_c[2] = in_tdata[2*W +: W];
  assign ra     = in_tdata[3*W +: W-1];
  assign b_c[0] = in_tdata[4*W-1 +: W];
  assign b_c[1] = in_tdata[5*W-1 +: W];
  assign b_c[2] = in_tdata[6*W-1 +: W];
  assign rb     = in_tdata[7*W-1 +: W-1];

  logic f_valid;
  logic [2*W+3:0] f_l2;
  logic signed [W-1:0] f_a [3];
  logic signed [W-1:0] f_b [3];
  logic [W-2:0] f_ra, f_rb;
  logic [W:0] f_dmag [3];
  logic [2:0] f_dneg;
  logic signed [W-1:0] f_rd;
  logic f_contain, f_take_a;

  bsm_front #(.W(W)) u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_tvalid && FRAC_ONE[FRACTION_BITS]),
    .a_c(a_c), .b_c(b_c), .ra(ra), .rb(rb),
    .out_valid(f_valid), .l2(f_l2), .a_o(f_a), .b_o(f_b), .ra_o(f_ra), .rb_o(f_rb),
    .dmag_o(f_dmag), .dneg_o(f_dneg), .rd_o(f_rd), .contain_o(f_contain),
    .take_a_o(f_take_a)
  );

  logic [SQW-1:0] sq_side, sq_side_o;
  logic sq_valid;
  logic [LB-1:0] sq_root;

  assign sq_side = {f_a[0], f_a[1], f_a[2], f_b[0], f_b[1], f_b[2], f_ra, f_rb, f_dneg,
                    f_contain, f_take_a, f_dmag[0], f_dmag[1], f_dmag[2], f_rd};

  bsm_sqrt #(.LB(LB), .SW(SQW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(f_valid), .n(f_l2), .side(sq_side),
    .out_valid(sq_valid), .root(sq_root), .side_o(sq_side_o)
  );

  logic [W:0] s_dmag [3];
  logic signed [W-1:0] s_rd;
  logic [DVW-1:0] dv_side, dv_side_o;

  assign s_rd      = sq_side_o[0 +: W];
  assign s_dmag[2] = sq_side_o[W +: W+1];
  assign s_dmag[1] = sq_side_o[2*W+1 +: W+1];
  assign s_dmag[0] = sq_side_o[3*W+2 +: W+1];
  assign dv_side   = {sq_side_o[SQW-1 -: KW], sq_root};

  logic dv_valid;
  logic [W:0] dv_q [3];
  logic [W+2:0] dv_rem [3];
  logic [W+2:0] dv_den;

  bsm_div #(.W(W), .SW(DVW)) u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(sq_valid), .len(sq_root), .rd(s_rd),
    .dmag(s_dmag), .side(dv_side), .out_valid(dv_valid), .quot(dv_q), .rem(dv_rem),
    .den(dv_den), .side_o(dv_side_o)
  );

  logic [KW-1:0] keep;
  logic [LB-1:0] k_len;
  logic signed [W-1:0] k_a [3];
  logic signed [W-1:0] k_b [3];
  logic [W-2:0] k_ra, k_rb;
  logic [2:0] k_dneg;
  logic k_contain, k_take_a;

  assign k_len     = dv_side_o[0 +: LB];
  assign keep      = dv_side_o[LB +: KW];
  assign k_take_a  = keep[0];
  assign k_contain = keep[1];
  assign k_dneg    = keep[4:2];
  assign k_rb      = keep[5 +: W-1];
  assign k_ra      = keep[W+4 +: W-1];
  assign k_b[2]    = keep[2*W+3 +: W];
  assign k_b[1]    = keep[3*W+3 +: W];
  assign k_b[0]    = keep[4*W+3 +: W];
  assign k_a[2]    = keep[5*W+3 +: W];
  assign k_a[1]    = keep[6*W+3 +: W];
  assign k_a[0]    = keep[7*W+3 +: W];

  logic [W:0] off [3];
  logic [W:0] soff [3];
  logic [W:0] cen [3];
  logic [LB:0] rsum;
  logic [LB:0] rhalf;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      off[k]  = dv_q[k] + {{W{1'b0}}, ({dv_rem[k], 1'b0} >= {1'b0, dv_den})};
      soff[k] = k_dneg[k] ? (~off[k] + 1'b1) : off[k];
      cen[k]  = {k_a[k][W-1], k_a[k]} + soff[k];
    end
    rsum  = {1'b0, k_len} + {{(LB-W+2){1'b0}}, k_ra} + {{(LB-W+2){1'b0}}, k_rb}
            + {{LB{1'b0}}, 1'b1};
    rhalf = {1'b0, rsum[LB:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (k_contain) begin
        for (int k = 0; k < 3; k++) out_c_r[k] <= k_take_a ? k_a[k] : k_b[k];
        out_r_r    <= k_take_a ? k_ra : k_rb;
        out_case_r <= k_take_a ? CASE_KEEP_A : CASE_TAKE_B;
        out_sat_r  <= 1'b0;
      end else begin
        for (int k = 0; k < 3; k++) out_c_r[k] <= cen[k][W-1:0];
        out_case_r <= CASE_NEW;
        if (rhalf > RMAX) begin
          out_r_r   <= RMAX[W-2:0];
          out_sat_r <= 1'b1;
        end else begin
          out_r_r   <= rhalf[W-2:0];
          out_sat_r <= 1'b0;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OTW-4*W+1){1'b0}}, out_r_r, out_c_r[2], out_c_r[1], out_c_r[0]};
  assign out_tuser  = {out_sat_r, out_case_r};

endmodule
